[rtl/triangle_pixel_shader_assert.svh]
// Assertion macros shared by the triangle pixel shader RTL.
`ifndef TRIANGLE_PIXEL_SHADER_ASSERT_SVH
`define TRIANGLE_PIXEL_SHADER_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define TPS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition in one cycle implies a condition in the following one.
`define TPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/tps_pkg.sv]
// Types and constants of the triangle pixel shader.
package tps_pkg;
	localparam int COORD_W = 16;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int WGT_W   = CROSS_W + 2;
	localparam int CH_W    = 8;
	localparam int BLEND_W = WGT_W + CH_W + 1;
	localparam int SUM_W   = BLEND_W + 2;
	localparam int PIX_W   = 10;
	localparam int VTX_W   = 56;
	localparam int FRAC_W  = 6;

	localparam logic [1:0] REG_VERTEX_A = 2'd0;
	localparam logic [1:0] REG_VERTEX_B = 2'd1;
	localparam logic [1:0] REG_VERTEX_C = 2'd2;

	typedef struct packed {
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
		logic             in_tri;
	} meta_t;

	typedef struct packed {
		logic signed [CROSS_W-1:0] den;
		logic signed [WGT_W-1:0]   na;
		logic signed [WGT_W-1:0]   nb;
		logic signed [WGT_W-1:0]   ng;
		meta_t                     meta;
	} weights_t;
endpackage

[rtl/triangle_pixel_shader.sv]
// Top level of the triangle pixel shader: vertex registers, flow control and output stage.
// One pixel is taken per clock through fifteen register stages: four of edge geometry and
// weights, two of colour products and sums, eight of the bit-serial divider (one quotient
// bit per stage, three channels side by side) and the output register. A stall on the
// output fills empty stages first and then holds the pipeline.
// Vertex registers are written through the cfg port, which is always ready.
module triangle_pixel_shader import tps_pkg::*; #(
	parameter int SCREEN_SIZE = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [23:0]        s_tdata,   // pixel_x, pixel_y, zero padding
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [47:0]        m_tdata,   // out_x, out_y, inside_res, red, green, blue, padding
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [VTX_W-1:0]   cfg_data
);
	`include "triangle_pixel_shader_assert.svh"

	localparam int NSTG = 15;

	logic [VTX_W-1:0] vtx_a_q, vtx_b_q, vtx_c_q;
	logic [NSTG:1] vld_q, en;
	weights_t wgt;
	logic signed [SUM_W-1:0] sum_s6 [3];
	logic signed [CROSS_W-1:0] den_s6;
	logic [CH_W-1:0] quo [3];
	meta_t meta_s [5:14];
	meta_t meta_s15;
	logic [CH_W-1:0] col_s15 [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_a_q <= '0;
			vtx_b_q <= '0;
			vtx_c_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_VERTEX_A: vtx_a_q <= cfg_data;
				REG_VERTEX_B: vtx_b_q <= cfg_data;
				REG_VERTEX_C: vtx_c_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or when the stage after it moves on.
	always_comb begin
		en[NSTG] = !vld_q[NSTG] || m_tready;
		for (int k = NSTG - 1; k >= 1; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1])
				vld_q[1] <= s_tvalid;
			for (int k = 2; k <= NSTG; k++)
				if (en[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = vld_q[NSTG];

	tps_geom #(.SCREEN_SIZE(SCREEN_SIZE)) u_geom (
		.clk     (clk),
		.en      (en[4:1]),
		.pixel_x (s_tdata[9:0]),
		.pixel_y (s_tdata[19:10]),
		.vtx_a   (vtx_a_q),
		.vtx_b   (vtx_b_q),
		.vtx_c   (vtx_c_q),
		.wgt     (wgt)
	);

	tps_blend u_blend (
		.clk    (clk),
		.en     (en[6:5]),
		.wgt    (wgt),
		.vtx_a  (vtx_a_q),
		.vtx_b  (vtx_b_q),
		.vtx_c  (vtx_c_q),
		.sum_s6 (sum_s6),
		.den_s6 (den_s6)
	);

	for (genvar c = 0; c < 3; c++) begin : g_div
		tps_div u_div (
			.clk (clk),
			.en  (en[14:7]),
			.num (sum_s6[c]),
			.den (den_s6),
			.quo (quo[c])
		);
	end

	always_ff @(posedge clk) begin
		if (en[5])
			meta_s[5] <= wgt.meta;
		for (int k = 6; k <= 14; k++)
			if (en[k])
				meta_s[k] <= meta_s[k-1];
		if (en[NSTG]) begin
			meta_s15 <= meta_s[14];
			for (int c = 0; c < 3; c++)
				col_s15[c] <= meta_s[14].in_tri ? quo[c] : '0;
		end
	end

	assign m_tdata = {3'b000, col_s15[2], col_s15[1], col_s15[0], meta_s15.in_tri,
		meta_s15.y, meta_s15.x};

	`TPS_ASSERT_IMP(a_outside_black, m_tvalid && !m_tdata[20], m_tdata[44:21] == 24'd0,
		"pixel outside the triangle carries a colour")
	`TPS_ASSERT_IMP(a_ready_follows, m_tready, s_tready,
		"input stalled although the output is taking results")
	`TPS_ASSERT_NEXT(a_held_result, m_tvalid && !m_tready, m_tvalid,
		"pending result dropped without a transfer")
endmodule

[rtl/tps_geom.sv]
// Four pipeline stages: edge vectors, products, cross products, then weights and inside test.
module tps_geom import tps_pkg::*; #(
	parameter int SCREEN_SIZE = 512
) (
	input  logic              clk,
	input  logic [4:1]        en,
	input  logic [PIX_W-1:0]  pixel_x,
	input  logic [PIX_W-1:0]  pixel_y,
	input  logic [VTX_W-1:0]  vtx_a,
	input  logic [VTX_W-1:0]  vtx_b,
	input  logic [VTX_W-1:0]  vtx_c,
	output weights_t          wgt
);
	localparam logic [PIX_W:0] SCREEN_LIM = (PIX_W+1)'(SCREEN_SIZE);

	logic signed [DIFF_W-1:0] dpx_s1, dpy_s1, cax_s1, cay_s1, bax_s1, bay_s1;
	logic [PIX_W-1:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3;
	logic signed [PROD_W-1:0] d0_s2, d1_s2, b0_s2, b1_s2, g0_s2, g1_s2;
	logic signed [CROSS_W-1:0] den_s3, nb_s3, ng_s3;
	logic signed [CROSS_W-1:0] den_abs;
	logic signed [WGT_W-1:0] nb_fix, ng_fix, na_fix;
	logic on_screen;

	function automatic logic signed [DIFF_W-1:0] sub16(input logic [COORD_W-1:0] p,
			input logic [COORD_W-1:0] q);
		return $signed({1'b0, p}) - $signed({1'b0, q});
	endfunction

	always_ff @(posedge clk) begin
		if (en[1]) begin
			dpx_s1 <= sub16({pixel_x, FRAC_W'(0)}, vtx_a[55:40]);
			dpy_s1 <= sub16({pixel_y, FRAC_W'(0)}, vtx_a[39:24]);
			cax_s1 <= sub16(vtx_c[55:40], vtx_a[55:40]);
			cay_s1 <= sub16(vtx_c[39:24], vtx_a[39:24]);
			bax_s1 <= sub16(vtx_b[55:40], vtx_a[55:40]);
			bay_s1 <= sub16(vtx_b[39:24], vtx_a[39:24]);
			x_s1 <= pixel_x;
			y_s1 <= pixel_y;
		end
		if (en[2]) begin
			d0_s2 <= cax_s1 * bay_s1;
			d1_s2 <= cay_s1 * bax_s1;
			b0_s2 <= cax_s1 * dpy_s1;
			b1_s2 <= cay_s1 * dpx_s1;
			g0_s2 <= dpx_s1 * bay_s1;
			g1_s2 <= dpy_s1 * bax_s1;
			x_s2 <= x_s1;
			y_s2 <= y_s1;
		end
		if (en[3]) begin
			den_s3 <= CROSS_W'(d0_s2) - CROSS_W'(d1_s2);
			nb_s3  <= CROSS_W'(b0_s2) - CROSS_W'(b1_s2);
			ng_s3  <= CROSS_W'(g0_s2) - CROSS_W'(g1_s2);
			x_s3 <= x_s2;
			y_s3 <= y_s2;
		end
		if (en[4]) begin
			wgt.den <= den_abs;
			wgt.na  <= na_fix;
			wgt.nb  <= nb_fix;
			wgt.ng  <= ng_fix;
			wgt.meta.x <= x_s3;
			wgt.meta.y <= y_s3;
			wgt.meta.in_tri <= (den_s3 != '0) && !na_fix[WGT_W-1] && !nb_fix[WGT_W-1]
				&& !ng_fix[WGT_W-1] && on_screen;
		end
	end

	// A clockwise triangle is turned round so that the weights share one sign.
	always_comb begin
		den_abs = den_s3[CROSS_W-1] ? -den_s3 : den_s3;
		nb_fix  = den_s3[CROSS_W-1] ? -WGT_W'(nb_s3) : WGT_W'(nb_s3);
		ng_fix  = den_s3[CROSS_W-1] ? -WGT_W'(ng_s3) : WGT_W'(ng_s3);
		na_fix  = WGT_W'(den_abs) - nb_fix - ng_fix;
		on_screen = ({1'b0, x_s3} < SCREEN_LIM) && ({1'b0, y_s3} < SCREEN_LIM);
	end
endmodule

[rtl/tps_blend.sv]
// Two pipeline stages: weight times colour for every channel, then the sums.
module tps_blend import tps_pkg::*; (
	input  logic                           clk,
	input  logic [6:5]                     en,
	input  weights_t                       wgt,
	input  logic [VTX_W-1:0]               vtx_a,
	input  logic [VTX_W-1:0]               vtx_b,
	input  logic [VTX_W-1:0]               vtx_c,
	output logic signed [SUM_W-1:0]        sum_s6 [3],
	output logic signed [CROSS_W-1:0]      den_s6
);
	logic signed [BLEND_W-1:0] pa_s5 [3], pb_s5 [3], pg_s5 [3];
	logic signed [CROSS_W-1:0] den_s5;

	function automatic logic signed [CH_W:0] chan(input logic [VTX_W-1:0] v, input int k);
		return $signed({1'b0, v[16-8*k +: CH_W]});
	endfunction

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int k = 0; k < 3; k++) begin
				pa_s5[k] <= wgt.na * chan(vtx_a, k);
				pb_s5[k] <= wgt.nb * chan(vtx_b, k);
				pg_s5[k] <= wgt.ng * chan(vtx_c, k);
			end
			den_s5 <= wgt.den;
		end
		if (en[6]) begin
			for (int k = 0; k < 3; k++)
				sum_s6[k] <= SUM_W'(pa_s5[k]) + SUM_W'(pb_s5[k]) + SUM_W'(pg_s5[k]);
			den_s6 <= den_s5;
		end
	end
endmodule

[rtl/tps_div.sv]
// Eight-stage restoring divider giving one quotient bit per stage.
module tps_div import tps_pkg::*; (
	input  logic                      clk,
	input  logic [CH_W-1:0]           en,
	input  logic signed [SUM_W-1:0]   num,
	input  logic signed [CROSS_W-1:0] den,
	output logic [CH_W-1:0]           quo
);
	// Inside the triangle the quotient is at most 255, so eight bits suffice.
	for (genvar j = 0; j < CH_W; j++) begin : g_step
		logic signed [SUM_W-1:0] rem_in, den_in, trial;
		logic [CH_W-1:0]         q_in;
		logic signed [SUM_W-1:0] rem_s, den_s;
		logic [CH_W-1:0]         q_s;
		logic take;
		if (j == 0) begin : g_src
			assign rem_in = num;
			assign den_in = SUM_W'(den);
			assign q_in   = '0;
		end else begin : g_src
			assign rem_in = g_step[j-1].rem_s;
			assign den_in = g_step[j-1].den_s;
			assign q_in   = g_step[j-1].q_s;
		end
		always_comb begin
			trial = den_in <<< (CH_W - 1 - j);
			take  = rem_in >= trial;
		end
		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_s <= take ? rem_in - trial : rem_in;
				den_s <= den_in;
				q_s   <= {q_in[CH_W-2:0], take};
			end
		end
	end

	assign quo = g_step[CH_W-1].q_s;
endmodule
